// File: hdl/key_typematic_repeat_assert.svh
// Assertion macros for the typematic repeat engine checker.
// Needs clk and rst in scope at the point of use.
`ifndef KEY_TYPEMATIC_REPEAT_ASSERT_SVH
`define KEY_TYPEMATIC_REPEAT_ASSERT_SVH

// same-cycle implication
`define KTR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KTR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ktr_pkg.sv
// Shared constants, codes and types of the typematic repeat engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ktr_pkg;

  localparam int NUM_KEYS  = 64;
  localparam int KEY_W     = 6;
  localparam int KEY_AW    = $clog2(NUM_KEYS);
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 2;
  localparam int EV_W      = 2;
  localparam int ST_W      = 3;

  // operations
  localparam logic [OP_W-1:0] OP_PRESS   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd2;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd3;

  // event kinds
  localparam logic [EV_W-1:0] EV_PRESSED  = 2'd0;
  localparam logic [EV_W-1:0] EV_REPEATED = 2'd1;
  localparam logic [EV_W-1:0] EV_RELEASED = 2'd2;
  localparam logic [EV_W-1:0] EV_QUERY    = 2'd3;

  // key status codes
  localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] ST_PRESSED  = 3'd1;
  localparam logic [ST_W-1:0] ST_FIRST    = 3'd2;
  localparam logic [ST_W-1:0] ST_REPEAT   = 3'd3;
  localparam logic [ST_W-1:0] ST_RELEASED = 3'd4;
  localparam logic [ST_W-1:0] ST_REL_IDLE = 3'd5;

  // config register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_INIT_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_IVL = 2'd1;
  localparam logic [CFG_W-1:0]     INIT_DELAY_RST = 16'd400;
  localparam logic [CFG_W-1:0]     REPEAT_IVL_RST = 16'd25;

  typedef struct packed {
    logic [ST_W-1:0]   st;
    logic [TIME_W-1:0] stamp;
  } key_ent_t;

  typedef struct packed {
    logic              rd_en;
    logic [KEY_AW-1:0] rd_addr;
    logic              we;
    logic [KEY_AW-1:0] wr_addr;
    key_ent_t          wr_data;
  } ram_req_t;

endpackage

`default_nettype wire

// File: hdl/ktr_ifs.sv
// Valid/ready channel interfaces: input word, event word, config write.
// Depends on ktr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ktr_in_if import ktr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [KEY_W-1:0]  key_index;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, operation, key_index, now_ms, input ready);
  modport sink (input valid, operation, key_index, now_ms, output ready);
endinterface

interface ktr_out_if import ktr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [EV_W-1:0]  event_kind;
  logic [KEY_W-1:0] event_key;
  logic             held;
  logic             last;
  modport source (output valid, event_kind, event_key, held, last, input ready);
  modport sink (input valid, event_kind, event_key, held, last, output ready);
endinterface

interface ktr_cfg_if import ktr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/key_typematic_repeat.sv
// Keyboard auto-repeat engine, top level: config registers, sequencer, key memory.
// Press/release hold ready low while the key entry is written; a query reply is loaded
// into the result register once it is free. Tick with the pending flag set: every key is
// scanned, one per cycle through the read port unless the result side stalls; else none.
// Ready only between items. Reset (sync, active high): keys idle with stamp zero via
// per-key valid bits, no clearing pass; delay 400 ms, interval 25 ms, pending clear.
// Depends on ktr_pkg, ktr_ifs, ktr_key_ram, ktr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module key_typematic_repeat import ktr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ktr_in_if.sink    item,
  ktr_out_if.source result,
  ktr_cfg_if.sink   cfg
);

  // timing registers
  logic [CFG_W-1:0] init_delay;
  logic [CFG_W-1:0] repeat_ivl;

  // key memory request and read data
  ram_req_t ram_req;
  key_ent_t rd_data;

  // config registers are to be written by the user only while idle; the block does not enforce it (ready tied high)
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_delay <= INIT_DELAY_RST;
      repeat_ivl <= REPEAT_IVL_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_INIT_DELAY: init_delay <= cfg.data;
        REG_REPEAT_IVL: repeat_ivl <= cfg.data;
        default: ;   // indexes past the list are dropped
      endcase
    end
  end

  // Sequencer: one key per cycle during a scan unless the result side stalls. The last event found in a
  // scan is held back one word so it can carry the last flag.
  ktr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .result     (result),
    .init_delay (init_delay),
    .repeat_ivl (repeat_ivl),
    .ram_req    (ram_req),
    .rd_data    (rd_data)
  );

  // status + stamp per key, registered read
  ktr_key_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (ram_req),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// File: hdl/ktr_key_ram.sv
// Per-key status/stamp memory, one write and one registered read per cycle.
// Per-entry valid bits make unwritten keys read as idle with stamp zero.
// Depends on ktr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ktr_key_ram import ktr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ram_req_t req,
  output key_ent_t rd_data
);

  key_ent_t            mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] vld;
  key_ent_t            rd_q;
  logic                rd_vld;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : key_ent_t'('0);

endmodule

`default_nettype wire

// File: hdl/ktr_elapsed.sv
// Shared elapsed-time unit: wrapping 32-bit subtract and compare to a limit.
// Depends on ktr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ktr_elapsed import ktr_pkg::*; (
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] stamp,
  input  logic [CFG_W-1:0]  limit,
  output logic              over
);

  logic [TIME_W-1:0] diff;

  assign diff = now - stamp;
  assign over = diff > TIME_W'(limit);

endmodule

`default_nettype wire

// File: hdl/ktr_ctrl.sv
// Sequencer: single-key operations, the key scan, one-word holdback for the
// last flag, and the result register. Depends on ktr_pkg, ktr_ifs, ktr_elapsed.
`timescale 1ns / 1ps
`default_nettype none

module ktr_ctrl import ktr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  ktr_in_if.sink           item,
  ktr_out_if.source        result,
  input  logic [CFG_W-1:0] init_delay,
  input  logic [CFG_W-1:0] repeat_ivl,
  output ram_req_t         ram_req,
  input  key_ent_t         rd_data
);

  typedef enum logic [1:0] {S_IDLE, S_OP, S_SCAN, S_FLUSH} state_t;

  state_t            state;
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  key_q;
  logic [TIME_W-1:0] now_q;
  logic              key_ok_q;
  logic [KEY_AW-1:0] cnt;
  logic              still;
  logic              pending;
  logic              hb_valid;
  logic [EV_W-1:0]   hb_kind;
  logic [KEY_W-1:0]  hb_key;
  logic              o_valid;
  logic [EV_W-1:0]   o_kind;
  logic [KEY_W-1:0]  o_key;
  logic              o_held;
  logic              o_last;

  logic              accept;
  logic              out_free;
  logic              key_ok_in;
  logic [CFG_W-1:0]  limit;
  logic              over;
  logic              fire;
  logic [EV_W-1:0]   kind;
  logic              wr_s;
  key_ent_t          ent_s;
  logic              active;
  logic              stall;
  logic              last_key;
  logic              o_load;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !o_valid || result.ready;
  assign key_ok_in  = {1'b0, item.key_index} < (KEY_W + 1)'(NUM_KEYS);
  assign last_key   = (cnt == KEY_AW'(NUM_KEYS - 1));

  assign result.valid      = o_valid;
  assign result.event_kind = o_kind;
  assign result.event_key  = o_key;
  assign result.held       = o_held;
  assign result.last       = o_last;

  assign limit = (rd_data.st == ST_FIRST) ? init_delay : repeat_ivl;

  ktr_elapsed u_elapsed (
    .now   (now_q),
    .stamp (rd_data.stamp),
    .limit (limit),
    .over  (over)
  );

  // per-key scan decision
  always_comb begin
    fire   = 1'b0;
    kind   = EV_PRESSED;
    wr_s   = 1'b0;
    ent_s  = rd_data;
    active = 1'b0;
    case (rd_data.st)
      ST_PRESSED: begin
        fire     = 1'b1;
        wr_s     = 1'b1;
        ent_s.st = ST_FIRST;
        active   = 1'b1;
      end
      ST_FIRST, ST_REPEAT: begin
        active = 1'b1;
        if (over) begin
          fire        = 1'b1;
          kind        = EV_REPEATED;
          wr_s        = 1'b1;
          ent_s.st    = ST_REPEAT;
          ent_s.stamp = now_q;
        end
      end
      ST_RELEASED: begin
        fire     = 1'b1;
        kind     = EV_RELEASED;
        wr_s     = 1'b1;
        ent_s.st = ST_REL_IDLE;
        active   = 1'b1;
      end
      ST_REL_IDLE: begin
        wr_s     = 1'b1;
        ent_s.st = ST_IDLE;
      end
      default: ;
    endcase
  end

  // a new event needs the holdback slot emptied into the result register
  assign stall = fire && hb_valid && !out_free;

  // result register loads: query reply, a held-back event, or the final event
  assign o_load = (state == S_OP && op_q == OP_QUERY && out_free) ||
                  (state == S_SCAN && !stall && fire && hb_valid) ||
                  (state == S_FLUSH && hb_valid && out_free);

  always_comb begin
    ram_req = '0;
    unique case (state)
      S_IDLE: begin
        ram_req.rd_en   = accept;
        ram_req.rd_addr = (item.operation == OP_TICK) ? '0 : item.key_index[KEY_AW-1:0];
      end
      S_OP: begin
        ram_req.wr_addr = key_q[KEY_AW-1:0];
        if (key_ok_q && op_q == OP_PRESS &&
            rd_data.st != ST_FIRST && rd_data.st != ST_REPEAT) begin
          ram_req.we      = 1'b1;
          ram_req.wr_data = '{st: ST_PRESSED, stamp: now_q};
        end else if (key_ok_q && op_q == OP_RELEASE) begin
          ram_req.we      = 1'b1;
          ram_req.wr_data = '{st: ST_RELEASED, stamp: rd_data.stamp};
        end
      end
      S_SCAN: begin
        ram_req.wr_addr = cnt;
        ram_req.wr_data = ent_s;
        ram_req.rd_addr = cnt + 1'b1;
        if (!stall) begin
          ram_req.we    = wr_s;
          ram_req.rd_en = !last_key;
        end
      end
      S_FLUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pending  <= 1'b0;
      still    <= 1'b0;
      cnt      <= '0;
      hb_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (result.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q     <= item.operation;
            key_q    <= item.key_index;
            now_q    <= item.now_ms;
            key_ok_q <= key_ok_in;
            cnt      <= '0;
            still    <= 1'b0;
            if (item.operation != OP_TICK) begin
              state <= S_OP;
            end else if (pending) begin
              state <= S_SCAN;
            end
          end
        end
        S_OP: begin
          unique case (op_q)
            OP_PRESS, OP_RELEASE: begin
              if (key_ok_q) begin
                pending <= 1'b1;
              end
              state <= S_IDLE;
            end
            OP_QUERY: begin
              if (out_free) begin
                o_kind  <= EV_QUERY;
                o_key   <= key_q;
                o_held  <= key_ok_q && (rd_data.st != ST_IDLE);
                o_last  <= 1'b1;
                state   <= S_IDLE;
              end
            end
            OP_TICK: state <= S_IDLE;
            default: state <= S_IDLE;
          endcase
        end
        S_SCAN: begin
          if (!stall) begin
            if (active) begin
              still <= 1'b1;
            end
            if (fire) begin
              if (hb_valid) begin
                o_kind  <= hb_kind;
                o_key   <= hb_key;
                o_held  <= 1'b0;
                o_last  <= 1'b0;
              end
              hb_valid <= 1'b1;
              hb_kind  <= kind;
              hb_key   <= KEY_W'(cnt);
            end
            if (last_key) begin
              state <= S_FLUSH;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          pending <= still;
          if (!hb_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            o_kind   <= hb_kind;
            o_key    <= hb_key;
            o_held   <= 1'b0;
            o_last   <= 1'b1;
            hb_valid <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/ktr_checker.sv
// Port-level checker for the typematic repeat engine, bound to the top level.
// Depends on ktr_pkg and key_typematic_repeat_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "key_typematic_repeat_assert.svh"

module ktr_checker import ktr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [OP_W-1:0]  in_op,
  input logic             out_valid,
  input logic             out_ready,
  input logic [EV_W-1:0]  out_kind,
  input logic [KEY_W-1:0] out_key,
  input logic             out_held,
  input logic             out_last
);

  `KTR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `KTR_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_kind) && $stable(out_key) && $stable(out_held) && $stable(out_last), "stalled result word changed")
  `KTR_ASSERT_NXT(a_busy_after, in_valid && in_ready && in_op != OP_TICK, !in_ready, "ready while an operation is in progress")
  `KTR_ASSERT_NOW(a_query_last, out_valid && out_kind == EV_QUERY, out_last, "query reply without last flag")

endmodule

bind key_typematic_repeat ktr_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .in_op     (item.operation),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_kind  (result.event_kind),
  .out_key   (result.event_key),
  .out_held  (result.held),
  .out_last  (result.last)
);

`default_nettype wire

// File: verif/key_typematic_repeat_test.sv
// Self-checking testbench for the keyboard auto-repeat engine key_typematic_repeat.
// Drives press/release/tick/query words, predicts the events and query replies, checks them.
// Depends on ktr_pkg, ktr_ifs and the RTL top level.
`timescale 1ns / 1ps

module key_typematic_repeat_test;
  import ktr_pkg::*;

  // A tick with many held keys can emit one word per key, each possibly stalled by the event side.
  // With ~460 words, each possibly such a tick plus gaps and a scan, this limit allows for that.
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  // A tick scan with no events still steps through all NUM_KEYS keys; wait for that plus slack.
  localparam int          DRAIN_CYCLES = NUM_KEYS + 8;

  typedef struct packed {
    logic [EV_W-1:0]  kind;
    logic [KEY_W-1:0] key;
    logic             held;
    logic             last;
  } key_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ktr_in_if  item_ch ();
  ktr_out_if ev_ch ();
  ktr_cfg_if cfg_ch ();

  key_typematic_repeat u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (ev_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted engine state: per-key status and stamp, scan flag, the two timers.
  // ---------------------------------------------------------------------------
  logic [ST_W-1:0]   key_phase    [NUM_KEYS];
  logic [TIME_W-1:0] key_stamp_ms [NUM_KEYS];
  logic              scan_armed;
  logic [CFG_W-1:0]  delay_ms;
  logic [CFG_W-1:0]  ivl_ms;

  key_event_t  due_events[$];   // events and replies still owed by the engine
  int          err_count   = 0;
  int unsigned cycle_count = 0;
  bit          tx_idle     = 1'b0;   // random gaps on the input side
  bit          rx_idle     = 1'b0;   // random stalls on the event side

  function automatic void reset_model();
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_phase[k]    = ST_IDLE;
      key_stamp_ms[k] = '0;
    end
    scan_armed = 1'b0;
    delay_ms   = INIT_DELAY_RST;
    ivl_ms     = REPEAT_IVL_RST;
  endfunction

  function automatic key_event_t make_event(logic [EV_W-1:0] kind, logic [KEY_W-1:0] key,
                                            logic held);
    key_event_t ev;
    ev.kind = kind;
    ev.key  = key;
    ev.held = held;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Apply one accepted word to the predicted state; queue what it should emit.
  function automatic void predict_word(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                                       logic [TIME_W-1:0] now);
    key_event_t        batch[$];
    key_event_t        ev;
    logic              live;
    logic [TIME_W-1:0] age;
    case (op)
      OP_PRESS: begin
        scan_armed = 1'b1;
        // a press never restarts a key that is already waiting or repeating
        if (key_phase[key] != ST_FIRST && key_phase[key] != ST_REPEAT) begin
          key_phase[key]    = ST_PRESSED;
          key_stamp_ms[key] = now;
        end
      end
      OP_RELEASE: begin
        scan_armed     = 1'b1;
        key_phase[key] = ST_RELEASED;
      end
      OP_QUERY: begin
        ev         = make_event(EV_QUERY, key, key_phase[key] != ST_IDLE);
        ev.last    = 1'b1;
        due_events = {due_events, ev};
      end
      default: begin
        if (scan_armed) begin
          live = 1'b0;
          for (int k = 0; k < NUM_KEYS; k++) begin
            age = now - key_stamp_ms[k];   // wraps mod 2^32
            case (key_phase[k])
              ST_PRESSED: begin
                batch = {batch, make_event(EV_PRESSED, KEY_W'(k), 1'b0)};
                key_phase[k] = ST_FIRST;
                live = 1'b1;
              end
              ST_FIRST: begin
                if (age > {16'd0, delay_ms}) begin
                  batch = {batch, make_event(EV_REPEATED, KEY_W'(k), 1'b0)};
                  key_phase[k]    = ST_REPEAT;
                  key_stamp_ms[k] = now;
                end
                live = 1'b1;
              end
              ST_REPEAT: begin
                if (age > {16'd0, ivl_ms}) begin
                  batch = {batch, make_event(EV_REPEATED, KEY_W'(k), 1'b0)};
                  key_stamp_ms[k] = now;
                end
                live = 1'b1;
              end
              ST_RELEASED: begin
                batch = {batch, make_event(EV_RELEASED, KEY_W'(k), 1'b0)};
                key_phase[k] = ST_REL_IDLE;
                live = 1'b1;
              end
              ST_REL_IDLE: key_phase[k] = ST_IDLE;   // silent, does not keep scan armed
              default: ;
            endcase
          end
          scan_armed = live;
          if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
          due_events = {due_events, batch};
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one word per call. valid stays high on return so that a
  // back-to-back word needs only one assignment in the acceptance step.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [TIME_W-1:0] now);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.operation <= op;
    item_ch.key_index <= key;
    item_ch.now_ms    <= now;
    item_ch.valid     <= 1'b1;
    do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
    predict_word(op, key, now);
  endtask

  // Drop valid, let all owed words arrive, then cover a tick scan with no events.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_idle();
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    cfg_ch.valid <= 1'b0;
    if (idx == REG_INIT_DELAY) delay_ms = data;
    else if (idx == REG_REPEAT_IVL) ivl_ms = data;
  endtask

  // ---------------------------------------------------------------------------
  // Event side: per-word stall, then compare against the oldest owed word.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  initial begin
    int         stall;
    key_event_t want;
    ev_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        ev_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      ev_ch.ready <= 1'b1;
      do @(posedge clk); while (!(ev_ch.valid && ev_ch.ready));
      if (due_events.size() == 0) begin
        $display("%0t: unexpected word, expected none actual kind %0d key %0d held %0d last %0d",
                 $time, ev_ch.event_kind, ev_ch.event_key, ev_ch.held, ev_ch.last);
        err_count++;
      end else begin
        want = due_events.pop_front();
        check_field("event_kind", want.kind, ev_ch.event_kind);
        check_field("event_key", want.key, ev_ch.event_key);
        check_field("held", want.held, ev_ch.held);
        check_field("last", want.last, ev_ch.last);
      end
    end
  end

  // hard stop
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Everything idle after reset; a tick with the scan flag clear emits nothing.
  task automatic test_idle_queries();
    send_word(OP_QUERY, 6'd0, 32'd0);
    send_word(OP_TICK, 6'd63, 32'hFFFF_FFFF);
    send_word(OP_QUERY, 6'd63, 32'hFFFF_FFFF);
  endtask

  // Reset timers 400/25: strict greater-than on both thresholds, press while
  // repeating is ignored, release then silent return to idle.
  task automatic test_repeat_timing();
    logic [TIME_W-1:0] t0;
    t0 = 32'd1000;
    send_word(OP_PRESS, 6'd5, t0);
    send_word(OP_TICK, 6'd0, t0);             // pressed
    send_word(OP_TICK, 6'd0, t0 + 400);       // exactly the delay: nothing
    send_word(OP_TICK, 6'd0, t0 + 401);       // first repeat, restamped
    send_word(OP_PRESS, 6'd5, t0 + 410);      // ignored while repeating
    send_word(OP_TICK, 6'd0, t0 + 426);       // exactly the interval: nothing
    send_word(OP_TICK, 6'd0, t0 + 427);       // repeat
    send_word(OP_RELEASE, 6'd5, t0 + 430);
    send_word(OP_TICK, 6'd0, t0 + 431);       // released
    send_word(OP_QUERY, 6'd5, t0 + 432);      // released-idle still counts as held
    send_word(OP_TICK, 6'd0, t0 + 433);       // goes idle silently, scan flag clears
    send_word(OP_QUERY, 6'd5, t0 + 434);
  endtask

  // Stamp just below the 32-bit wrap; release of a key that was never pressed.
  task automatic test_time_wrap();
    send_word(OP_PRESS, 6'd63, 32'hFFFF_FFF0);
    send_word(OP_TICK, 6'd0, 32'hFFFF_FFF0);
    send_word(OP_TICK, 6'd0, 32'h0000_01A0);  // 432 ms later across the wrap
    send_word(OP_RELEASE, 6'd63, 32'h0000_01A1);
    send_word(OP_RELEASE, 6'd32, 32'h0000_01A2);
    send_word(OP_TICK, 6'd0, 32'h0000_01A3);  // two released events, ascending keys
    send_word(OP_TICK, 6'd0, 32'h0000_01A4);
  endtask

  // Both timers at zero, then both at their maximum, with one key held across.
  task automatic test_config_extremes();
    write_reg(REG_INIT_DELAY, 16'd0);
    write_reg(REG_REPEAT_IVL, 16'd0);
    send_word(OP_PRESS, 6'd10, 32'd100);
    send_word(OP_TICK, 6'd0, 32'd100);
    send_word(OP_TICK, 6'd0, 32'd100);        // zero elapsed is not past a zero delay
    send_word(OP_TICK, 6'd0, 32'd101);
    write_reg(REG_INIT_DELAY, 16'hFFFF);
    write_reg(REG_REPEAT_IVL, 16'hFFFF);
    send_word(OP_TICK, 6'd0, 32'd101 + 32'd65535);
    send_word(OP_TICK, 6'd0, 32'd101 + 32'd65536);
    send_word(OP_RELEASE, 6'd10, 32'd200_000);
    send_word(OP_TICK, 6'd0, 32'd200_001);
    send_word(OP_TICK, 6'd0, 32'd200_002);
  endtask

  // Keys are drawn mostly from two small groups at the ends of the range so
  // that presses and releases meet the same keys often.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 2) == 0) return KEY_W'($urandom_range(0, NUM_KEYS - 1));
    return {($urandom_range(0, 1) != 0) ? 3'b111 : 3'b000, 3'($urandom_range(0, 7))};
  endfunction

  task automatic run_random_phase(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] ivl,
                                  input int unsigned step_max, input int count);
    logic [TIME_W-1:0] cur_ms;
    int                roll;
    write_reg(REG_INIT_DELAY, delay);
    write_reg(REG_REPEAT_IVL, ivl);
    cur_ms = $urandom;
    for (int n = 0; n < count; n++) begin
      if (n % 27 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        cur_ms = cur_ms + $urandom_range(0, step_max);
        // now and then a tick with an arbitrary time stamp
        send_word(OP_TICK, pick_key(), (roll < 3) ? $urandom : cur_ms);
      end else if (roll < 62) begin
        send_word(OP_PRESS, pick_key(), cur_ms);
      end else if (roll < 80) begin
        send_word(OP_RELEASE, pick_key(), cur_ms);
      end else begin
        send_word(OP_QUERY, pick_key(), $urandom);
      end
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_random_phase(16'($urandom_range(0, 60)), 16'($urandom_range(0, 20)), 30, 108);
    run_random_phase(16'd0, 16'd0, 3, 108);
    run_random_phase(16'hFFFF, 16'hFFFF, 40000, 108);
    run_random_phase(INIT_DELAY_RST, REPEAT_IVL_RST, 150, 108);
  endtask

  initial begin
    item_ch.valid     <= 1'b0;
    item_ch.operation <= OP_PRESS;
    item_ch.key_index <= '0;
    item_ch.now_ms    <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_INIT_DELAY;
    cfg_ch.data       <= '0;
    reset_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle = 1'b1;
    rx_idle = 1'b1;
    test_idle_queries();
    test_repeat_timing();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    test_time_wrap();
    tx_idle = 1'b1;
    test_config_extremes();
    test_random_traffic();

    wait_idle();
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ktr_pkg.sv
hdl/ktr_ifs.sv
hdl/ktr_key_ram.sv
hdl/ktr_elapsed.sv
hdl/ktr_ctrl.sv
hdl/key_typematic_repeat.sv
hdl/ktr_checker.sv
verif/key_typematic_repeat_test.sv
